@@ design/lra_pkg.sv @@
// ----------------------------------------------------------------------------
// lra_pkg: shared definitions of the link rate adaptation block
// sizes, field codes, register indexes and the packed result item layout
// ----------------------------------------------------------------------------
package lra_pkg;

  localparam int CHANNELS = 32;
  localparam int WINDOW   = 8;

  localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WP_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FC_W   = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(255 * WINDOW + 1);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int Q8_W   = 9;
  localparam int PROD_W = SUM_W + Q8_W;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [Q8_W-1:0] THRESH_UP_RST   = 9'd26;
  localparam logic [Q8_W-1:0] THRESH_DOWN_RST = 9'd128;
  localparam logic [Q8_W-1:0] THRESH_DROP_RST = 9'd230;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VARIANT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOPPING_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_UP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_DOWN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_DROP   = 3'd6;

  typedef enum logic [1:0] {
    FUNC_REPORT = 2'd0,
    FUNC_DECIDE = 2'd1,
    FUNC_SET    = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ADV_SAME = 2'd0,
    ADV_UP   = 2'd1,
    ADV_DOWN = 2'd2,
    ADV_DROP = 2'd3
  } advice_t;

  typedef enum logic [1:0] {
    RC_NONE    = 2'd0,
    RC_ABOVE   = 2'd1,
    RC_DROPPED = 2'd2,
    RC_AT_BASE = 2'd3
  } rcode_t;

  // result item as carried on out_tdata, last field in the lowest bits
  typedef struct packed {
    logic [1:0] pad;
    rcode_t     reset_code;
    logic [4:0] variant;
    logic [3:0] undecoded;
    logic       reject;
    advice_t    advice;
  } result_t;

endpackage

@@ design/link_rate_adaptation.sv @@
// ----------------------------------------------------------------------------
// link_rate_adaptation: per-channel link speed adapter
// sliding error window per channel, q8 ratio judgement and variant stepping
// ----------------------------------------------------------------------------
// The block takes one item per clock unless out_tready stalls it and gives
// one result item per item, in order, through the input register, the
// update stage register and the result register; with out_tready held high
// the sustained rate is one item per cycle. That rate is set by the update
// stage, which does the whole read-modify-write of one channel's statistics
// there: the window slot pointer and the window entry being overwritten are
// forwarded from the update stage to the input stage, so items for the same
// channel may follow each other back to back. The window memory needs no
// clearing pass after reset. Configuration registers are written through
// cfg_we/cfg_index/cfg_data, by the user only while no item is in flight, as
// the block does not check it; start_variant sets every channel's variant index.
// ----------------------------------------------------------------------------
module link_rate_adaptation (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // config write port
  input  logic                                  cfg_we,
  input  logic [lra_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lra_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // channel[4:0], err_count[12:5], err_max[20:13], variant_value[25:21], zero
  input  logic [lra_pkg::IN_TDATA_W-1:0]        in_tdata,
  // func[1:0]
  input  logic [lra_pkg::IN_TUSER_W-1:0]        in_tuser,
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // advice[1:0], reject[2], undecoded[6:3], variant[11:7], reset_code[13:12],
  // zero
  output logic [lra_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int CH_IW  = lra_pkg::CH_IW;
  localparam int WP_W   = lra_pkg::WP_W;
  localparam int FC_W   = lra_pkg::FC_W;
  localparam int SUM_W  = lra_pkg::SUM_W;
  localparam int ADDR_W = lra_pkg::ADDR_W;
  localparam int PROD_W = lra_pkg::PROD_W;
  localparam int Q8_W   = lra_pkg::Q8_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [4:0]      group_low_r, group_high_r;
  logic [31:0]     hop_mask_r;
  logic [Q8_W-1:0] thr_up_r, thr_down_r, thr_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_low_r  <= '0;
      group_high_r <= '0;
      hop_mask_r   <= '0;
      thr_up_r     <= lra_pkg::THRESH_UP_RST;
      thr_down_r   <= lra_pkg::THRESH_DOWN_RST;
      thr_drop_r   <= lra_pkg::THRESH_DROP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lra_pkg::REG_GROUP_LOW:    group_low_r  <= cfg_data[4:0];
        lra_pkg::REG_GROUP_HIGH:   group_high_r <= cfg_data[4:0];
        lra_pkg::REG_HOPPING_MASK: hop_mask_r   <= cfg_data;
        lra_pkg::REG_THRESH_UP:    thr_up_r     <= cfg_data[Q8_W-1:0];
        lra_pkg::REG_THRESH_DOWN:  thr_down_r   <= cfg_data[Q8_W-1:0];
        lra_pkg::REG_THRESH_DROP:  thr_drop_r   <= cfg_data[Q8_W-1:0];
        default: ;  // start_variant acts on the variant table below
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: everything past the input register moves together
  // --------------------------------------------------------------------------
  logic out_tvalid_r;
  logic s1_v_r, s2_v_r;
  logic adv;     // update stage commits and result register loads
  logic in_acc;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  lra_pkg::func_t s1_func_r;
  logic [4:0]     s1_ch_r, s1_vv_r;
  logic [7:0]     s1_e_r, s1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= lra_pkg::func_t'(in_tuser[1:0]);
      s1_ch_r   <= in_tdata[4:0];
      s1_e_r    <= in_tdata[12:5];
      s1_m_r    <= in_tdata[20:13];
      s1_vv_r   <= in_tdata[25:21];
    end
  end

  // --------------------------------------------------------------------------
  // per-channel state
  // --------------------------------------------------------------------------
  logic [WP_W-1:0]       wp_r     [lra_pkg::CHANNELS];
  logic [FC_W-1:0]       fill_r   [lra_pkg::CHANNELS];
  logic [SUM_W-1:0]      esum_r   [lra_pkg::CHANNELS];
  logic [SUM_W-1:0]      msum_r   [lra_pkg::CHANNELS];
  logic [FC_W-1:0]       undec_r  [lra_pkg::CHANNELS];
  lra_pkg::advice_t      advice_r [lra_pkg::CHANNELS];
  logic                  reject_r [lra_pkg::CHANNELS];
  logic [4:0]            var_r    [lra_pkg::CHANNELS];

  // --------------------------------------------------------------------------
  // update stage registers
  // --------------------------------------------------------------------------
  lra_pkg::func_t  s2_func_r;
  logic [4:0]      s2_ch_r, s2_vv_r;
  logic [7:0]      s2_e_r, s2_m_r;
  logic [WP_W-1:0] s2_wp_r;
  logic [15:0]     rd_r;       // window entry at the slot about to be written

  logic [CH_IW-1:0] s1_idx, s2_idx;
  logic             s2_ok;
  logic             s2_hit;
  logic [WP_W-1:0]  s1_wp;
  logic [WP_W-1:0]  wp_n;

  assign s1_idx = CH_IW'(s1_ch_r);
  assign s2_idx = CH_IW'(s2_ch_r);
  assign s2_ok  = 32'(s2_ch_r) < lra_pkg::CHANNELS;

  // pointer forwarding from an update of the same channel in flight
  assign s2_hit = s2_v_r && s2_ok && (s2_idx == s1_idx);
  assign s1_wp  = s2_hit ? wp_n : wp_r[s1_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_func_r <= s1_func_r;
      s2_ch_r   <= s1_ch_r;
      s2_e_r    <= s1_e_r;
      s2_m_r    <= s1_m_r;
      s2_vv_r   <= s1_vv_r;
      s2_wp_r   <= s1_wp;
    end
  end

  // --------------------------------------------------------------------------
  // window memory: {err, max} per slot, one write and one read per cycle
  // --------------------------------------------------------------------------
  logic [15:0]       win_mem [lra_pkg::DEPTH];
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              mem_we;

  assign rd_addr = ADDR_W'(s1_idx) * ADDR_W'(lra_pkg::WINDOW) + ADDR_W'(s1_wp);
  assign wr_addr = ADDR_W'(s2_idx) * ADDR_W'(lra_pkg::WINDOW) + ADDR_W'(s2_wp_r);
  assign mem_we  = adv && s2_v_r && s2_ok && (s2_func_r == lra_pkg::FUNC_REPORT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wr_addr] <= {s2_e_r, s2_m_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // same slot written in this cycle: take the new entry
      if (mem_we && (wr_addr == rd_addr)) begin
        rd_r <= {s2_e_r, s2_m_r};
      end else begin
        rd_r <= win_mem[rd_addr];
      end
    end
  end

  // --------------------------------------------------------------------------
  // update logic for the channel in the update stage
  // --------------------------------------------------------------------------
  logic [FC_W-1:0]   cur_fill, cur_undec;
  logic [SUM_W-1:0]  cur_esum, cur_msum;
  lra_pkg::advice_t  cur_adv;
  logic              cur_rej;
  logic [4:0]        cur_var;
  logic [7:0]        old_e, old_m;
  logic              full;

  logic [SUM_W-1:0]  rep_esum, rep_msum;
  logic [FC_W-1:0]   rep_fill, rep_undec;
  logic [WP_W-1:0]   rep_wp;
  logic [PROD_W-1:0] lhs, p_up, p_down, p_drop;
  logic              judge_en;
  lra_pkg::advice_t  jadv;
  logic              jrej;

  logic [FC_W-1:0]   fill_n, undec_n;
  logic [SUM_W-1:0]  esum_n, msum_n;
  lra_pkg::advice_t  adv_n;
  logic              rej_n;
  logic [4:0]        var_n;
  lra_pkg::rcode_t   code;
  logic              clr;

  assign cur_fill  = fill_r[s2_idx];
  assign cur_undec = undec_r[s2_idx];
  assign cur_esum  = esum_r[s2_idx];
  assign cur_msum  = msum_r[s2_idx];
  assign cur_adv   = advice_r[s2_idx];
  assign cur_rej   = reject_r[s2_idx];
  assign cur_var   = var_r[s2_idx];
  assign old_e     = rd_r[15:8];
  assign old_m     = rd_r[7:0];
  assign full      = cur_fill >= FC_W'(lra_pkg::WINDOW);

  // report: retire the oldest slot once the window is full, add the new one
  assign rep_esum  = (full ? cur_esum - SUM_W'(old_e) : cur_esum) + SUM_W'(s2_e_r);
  assign rep_msum  = (full ? cur_msum - SUM_W'(old_m) : cur_msum) + SUM_W'(s2_m_r);
  assign rep_fill  = full ? cur_fill : cur_fill + FC_W'(1);
  assign rep_undec = cur_undec - FC_W'(full && (old_e >= old_m))
                               + FC_W'(s2_e_r >= s2_m_r);
  assign rep_wp    = (32'(s2_wp_r) == lra_pkg::WINDOW - 1) ? '0 : s2_wp_r + WP_W'(1);

  // ratio against q8 thresholds by cross multiplication
  assign lhs      = PROD_W'({rep_esum, 8'd0});
  assign p_up     = PROD_W'(thr_up_r) * PROD_W'(rep_msum);
  assign p_down   = PROD_W'(thr_down_r) * PROD_W'(rep_msum);
  assign p_drop   = PROD_W'(thr_drop_r) * PROD_W'(rep_msum);
  assign judge_en = (rep_fill == FC_W'(lra_pkg::WINDOW)) && (rep_msum != '0);

  // later rules win, as the thresholds need not be ordered
  always_comb begin
    jadv = cur_adv;
    jrej = cur_rej;
    if (lhs <= p_up) begin
      jadv = (cur_var < group_high_r) ? lra_pkg::ADV_UP : lra_pkg::ADV_SAME;
    end
    if (lhs > p_up && lhs <= p_down) begin
      jadv = lra_pkg::ADV_SAME;
    end
    if (lhs > p_down && lhs <= p_drop) begin
      jadv = (cur_var > group_low_r) ? lra_pkg::ADV_DOWN : lra_pkg::ADV_SAME;
    end
    if (lhs > p_drop) begin
      jadv = lra_pkg::ADV_DROP;
      if (hop_mask_r[cur_var]) begin
        jrej = 1'b1;
      end
    end
  end

  always_comb begin
    fill_n  = cur_fill;
    undec_n = cur_undec;
    esum_n  = cur_esum;
    msum_n  = cur_msum;
    wp_n    = s2_wp_r;
    adv_n   = cur_adv;
    rej_n   = cur_rej;
    var_n   = cur_var;
    code    = lra_pkg::RC_NONE;
    clr     = 1'b0;
    case (s2_func_r)
      lra_pkg::FUNC_REPORT: begin
        fill_n  = rep_fill;
        undec_n = rep_undec;
        esum_n  = rep_esum;
        msum_n  = rep_msum;
        wp_n    = rep_wp;
        if (judge_en) begin
          adv_n = jadv;
          rej_n = jrej;
        end
      end
      lra_pkg::FUNC_DECIDE: begin
        if (cur_adv == lra_pkg::ADV_UP && cur_var < group_high_r) begin
          clr   = 1'b1;
          var_n = cur_var + 5'd1;
        end else if (cur_adv == lra_pkg::ADV_DOWN && cur_var > group_low_r) begin
          clr   = 1'b1;
          var_n = cur_var - 5'd1;
        end
        code = (var_n != group_low_r) ? lra_pkg::RC_ABOVE : lra_pkg::RC_NONE;
        if (cur_adv == lra_pkg::ADV_DROP) begin
          clr = 1'b1;
          if (var_n != group_low_r) begin
            var_n = group_low_r;
            code  = lra_pkg::RC_DROPPED;
          end else begin
            code  = lra_pkg::RC_AT_BASE;
          end
        end
        if (clr) begin
          fill_n  = '0;
          undec_n = '0;
          esum_n  = '0;
          msum_n  = '0;
          wp_n    = '0;
          adv_n   = lra_pkg::ADV_SAME;
          rej_n   = 1'b0;
        end
      end
      lra_pkg::FUNC_SET: begin
        var_n = s2_vv_r;
      end
      default: ;  // no operation: report state only
    endcase
  end

  // --------------------------------------------------------------------------
  // state write-back
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lra_pkg::CHANNELS; i++) begin
        wp_r[i]     <= '0;
        fill_r[i]   <= '0;
        esum_r[i]   <= '0;
        msum_r[i]   <= '0;
        undec_r[i]  <= '0;
        advice_r[i] <= lra_pkg::ADV_SAME;
        reject_r[i] <= 1'b0;
        var_r[i]    <= '0;
      end
    end else begin
      if (adv && s2_v_r && s2_ok) begin
        wp_r[s2_idx]     <= wp_n;
        fill_r[s2_idx]   <= fill_n;
        esum_r[s2_idx]   <= esum_n;
        msum_r[s2_idx]   <= msum_n;
        undec_r[s2_idx]  <= undec_n;
        advice_r[s2_idx] <= adv_n;
        reject_r[s2_idx] <= rej_n;
        var_r[s2_idx]    <= var_n;
      end
      // start of adaptation: every channel takes the start variant
      if (cfg_we && cfg_index == lra_pkg::REG_START_VARIANT) begin
        for (int i = 0; i < lra_pkg::CHANNELS; i++) begin
          var_r[i] <= cfg_data[4:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  lra_pkg::result_t res_nxt, out_res_r;

  always_comb begin
    res_nxt = '0;
    if (s2_ok) begin
      res_nxt.advice     = adv_n;
      res_nxt.reject     = rej_n;
      res_nxt.undecoded  = 4'(undec_n);
      res_nxt.variant    = var_n;
      res_nxt.reset_code = code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_res_r;

endmodule

@@ design/lra_checker.sv @@
// ----------------------------------------------------------------------------
// lra_checker: port-level checks of the link rate adaptation block
// result channel handshake, reset, undecoded range and consistency of decide results
// ----------------------------------------------------------------------------
module lra_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lra_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  lra_pkg::result_t res;

  assign res = lra_pkg::result_t'(out_tdata);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // a drop clears the channel statistics in the same result
  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.reset_code == lra_pkg::RC_DROPPED ||
                   res.reset_code == lra_pkg::RC_AT_BASE)
    |-> res.advice == lra_pkg::ADV_SAME && !res.reject && res.undecoded == 4'd0)
    else $error("drop result with statistics left");

  // undecodable slot count never exceeds the window, padding stays zero
  a_undec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(res.undecoded) <= lra_pkg::WINDOW && res.pad == 2'd0)
    else $error("undecoded count out of range");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind link_rate_adaptation lra_checker u_lra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
